/* hdl/nwsx_pkg.sv */
// shared codes and types of the no-wait shared/exclusive lock table
package nwsx_pkg;

  localparam logic [1:0] OP_LOCK_SH = 2'd0;
  localparam logic [1:0] OP_LOCK_EX = 2'd1;
  localparam logic [1:0] OP_UNLOCK  = 2'd2;

  localparam logic [2:0] PH_DEFAULT   = 3'd0;
  localparam logic [2:0] PH_GROWING   = 3'd1;
  localparam logic [2:0] PH_SHRINKING = 3'd2;
  localparam logic [2:0] PH_COMMITTED = 3'd3;
  localparam logic [2:0] PH_ABORTED   = 3'd4;

  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_REFUSED        = 3'd1;
  localparam logic [2:0] ST_ABORT_SHRINK   = 3'd2;
  localparam logic [2:0] ST_ABORT_CONFLICT = 3'd3;
  localparam logic [2:0] ST_TABLE_FULL     = 3'd4;
  localparam logic [2:0] ST_HOLDERS_FULL   = 3'd5;

  localparam logic [1:0] GM_NONE   = 2'd0;
  localparam logic [1:0] GM_SHARED = 2'd1;
  localparam logic [1:0] GM_EXCL   = 2'd2;

  localparam int OBJ_W  = 33;
  localparam int SLOT_W = 17;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] txn_id;
    logic [OBJ_W-1:0] obj;
  } req_t;

  typedef struct packed {
    logic [15:0] txn;
    logic        excl;
  } slot_t;

endpackage

/* hdl/nwsx_if.sv */
// request and result channel interfaces
interface nwsx_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] txn_id;
  logic [2:0]  txn_phase;
  logic [31:0] resource_key;
  logic        resource_is_record;
  modport source (output valid, opcode, txn_id, txn_phase, resource_key,
                  resource_is_record, input ready);
  modport sink (input valid, opcode, txn_id, txn_phase, resource_key,
                resource_is_record, output ready);
endinterface

interface nwsx_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [2:0] new_txn_phase;
  logic       add_to_lock_set;
  logic [1:0] group_mode;
  modport source (output valid, status, new_txn_phase, add_to_lock_set, group_mode,
                  input ready);
  modport sink (input valid, status, new_txn_phase, add_to_lock_set, group_mode,
                output ready);
endinterface

/* hdl/nwsx_ram.sv */
// generic simple dual-port ram with registered read
module nwsx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* hdl/no_wait_shared_exclusive_lock_table_core.sv */
// top level of the no-wait shared/exclusive lock table
// One request at a time. A lock or unlock that passes the phase check scans
// the object and holder mask memories for its entry (one entry per cycle
// through the registered read ports). If the entry is found, or a free one is
// taken for a lock, it fetches a found entry's holder mask, walks the holder
// slots and writes back, then presents the result; otherwise, and for requests
// refused by the phase check, it goes straight to the result. The next
// request is taken once the result is loaded into the output register. No
// clearing pass is needed after reset.
module no_wait_shared_exclusive_lock_table_core #(
  parameter int TABLE_ENTRIES     = 64,
  parameter int HOLDERS_PER_ENTRY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  nwsx_in_if.sink     in_ch,
  nwsx_out_if.source  out_ch
);
  localparam int T    = TABLE_ENTRIES;
  localparam int H    = HOLDERS_PER_ENTRY;
  localparam int EW   = $clog2(T);
  localparam int ECW  = $clog2(T + 1);
  localparam int HW   = (H > 1) ? $clog2(H) : 1;
  localparam int HCW  = $clog2(H + 1);
  localparam int SD   = T << HW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_PICK  = 3'd2;
  localparam logic [2:0] S_HMASK = 3'd3;
  localparam logic [2:0] S_WALK  = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  logic [2:0]       state_r;
  nwsx_pkg::req_t   req_r;
  logic [2:0]       phase_r;
  logic [2:0]       status_r;
  logic             add_r;
  logic [1:0]       group_r;

  logic             used_r  [T];

  logic [ECW-1:0]   ecnt_r;
  logic             found_r;
  logic [EW-1:0]    found_idx_r;
  logic             free_ok_r;
  logic [EW-1:0]    free_idx_r;
  logic [EW-1:0]    ent_r;
  logic [H-1:0]     mask_r;

  logic [HCW-1:0]   hcnt_r;
  logic             hit_r;
  logic [HW-1:0]    hit_idx_r;
  logic             hit_excl_r;
  logic             sfree_ok_r;
  logic [HW-1:0]    sfree_idx_r;
  logic [HCW-1:0]   nheld_r;
  logic             ex_r;
  logic             sh_r;

  logic             out_valid_r;
  logic [2:0]       out_status_r;
  logic [2:0]       out_phase_r;
  logic             out_add_r;
  logic [1:0]       out_group_r;

  // memories
  logic                       obj_we;
  logic [nwsx_pkg::OBJ_W-1:0] obj_rdata;
  logic                       mask_we;
  logic [EW-1:0]              mask_waddr;
  logic [H-1:0]               mask_wdata;
  logic [EW-1:0]              mask_raddr;
  logic [H-1:0]               mask_rdata;
  logic                       slot_we;
  logic [$clog2(SD)-1:0]      slot_waddr;
  nwsx_pkg::slot_t            slot_wdata;
  nwsx_pkg::slot_t            slot_rdata;

  // the mask memory follows the scan, then serves the found entry
  assign mask_raddr = (state_r == S_SCAN) ? ecnt_r[EW-1:0] : found_idx_r;

  nwsx_ram #(.WIDTH(nwsx_pkg::OBJ_W), .DEPTH(T)) u_obj_ram (
    .clk   (clk),
    .we    (obj_we),
    .waddr (free_idx_r),
    .wdata (req_r.obj),
    .raddr (ecnt_r[EW-1:0]),
    .rdata (obj_rdata)
  );

  nwsx_ram #(.WIDTH(H), .DEPTH(T)) u_mask_ram (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .raddr (mask_raddr),
    .rdata (mask_rdata)
  );

  nwsx_ram #(.WIDTH(nwsx_pkg::SLOT_W), .DEPTH(SD)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr ({ent_r, hcnt_r[HW-1:0]}),
    .rdata (slot_rdata)
  );

  // compare indexes name the entry whose read was issued in the previous cycle
  logic [EW-1:0] eprev;
  logic [HW-1:0] hprev;
  logic          is_lock;
  logic          is_ex;
  logic [1:0]    cur_group;
  logic [1:0]    rec_group;
  logic          out_free;

  assign eprev     = EW'(ecnt_r - ECW'(1));
  assign hprev     = HW'(hcnt_r - HCW'(1));
  assign is_lock   = (req_r.opcode == nwsx_pkg::OP_LOCK_SH) ||
                     (req_r.opcode == nwsx_pkg::OP_LOCK_EX);
  assign is_ex     = (req_r.opcode == nwsx_pkg::OP_LOCK_EX);
  // group mode of the entry as found by the holder walk
  assign cur_group = (ex_r || (hit_r && hit_excl_r)) ? nwsx_pkg::GM_EXCL :
                     ((sh_r || hit_r) ? nwsx_pkg::GM_SHARED : nwsx_pkg::GM_NONE);
  assign rec_group = ex_r ? nwsx_pkg::GM_EXCL :
                     (sh_r ? nwsx_pkg::GM_SHARED : nwsx_pkg::GM_NONE);
  assign out_free  = !out_valid_r || out_ch.ready;

  // write-back decisions
  always_comb begin
    obj_we     = 1'b0;
    mask_we    = 1'b0;
    mask_waddr = ent_r;
    mask_wdata = mask_r;
    slot_we    = 1'b0;
    slot_waddr = {ent_r, sfree_idx_r};
    slot_wdata = '{txn: req_r.txn_id, excl: is_ex};
    if (state_r == S_PICK && !found_r && is_lock && free_ok_r) begin
      obj_we     = 1'b1;
      mask_we    = 1'b1;
      mask_waddr = free_idx_r;
      mask_wdata = '0;
    end
    if (state_r == S_WRITE) begin
      if (is_lock) begin
        if (hit_r) begin
          slot_waddr = {ent_r, hit_idx_r};
          slot_wdata = '{txn: req_r.txn_id, excl: 1'b1};
          slot_we    = is_ex && !hit_excl_r && (nheld_r == HCW'(1));
        end else if (!((!is_ex && cur_group == nwsx_pkg::GM_EXCL) ||
                       (is_ex && cur_group != nwsx_pkg::GM_NONE)) && sfree_ok_r) begin
          slot_we    = 1'b1;
          mask_we    = 1'b1;
          mask_wdata = mask_r | (H'(1) << sfree_idx_r);
        end
      end else if (hit_r) begin
        mask_we    = 1'b1;
        mask_wdata = mask_r & ~(H'(1) << hit_idx_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < T; i++) begin
        used_r[i] <= 1'b0;
      end
    end else begin
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            unique case (in_ch.opcode) inside
              nwsx_pkg::OP_LOCK_SH, nwsx_pkg::OP_LOCK_EX: begin
                if (in_ch.txn_phase == nwsx_pkg::PH_DEFAULT ||
                    in_ch.txn_phase == nwsx_pkg::PH_GROWING) begin
                  state_r <= S_SCAN;
                end else begin
                  state_r <= S_DONE;
                end
              end
              nwsx_pkg::OP_UNLOCK: begin
                if (in_ch.txn_phase != nwsx_pkg::PH_COMMITTED &&
                    in_ch.txn_phase != nwsx_pkg::PH_ABORTED) begin
                  state_r <= S_SCAN;
                end else begin
                  state_r <= S_DONE;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_SCAN: begin
          if (ecnt_r == ECW'(T)) begin
            state_r <= S_PICK;
          end
        end
        S_PICK: begin
          if (found_r) begin
            state_r <= S_HMASK;
          end else if (is_lock && free_ok_r) begin
            used_r[free_idx_r] <= 1'b1;
            state_r            <= S_WALK;
          end else begin
            state_r <= S_DONE;
          end
        end
        S_HMASK: state_r <= S_WALK;
        S_WALK: begin
          if (hcnt_r == HCW'(H)) begin
            state_r <= S_WRITE;
          end
        end
        S_WRITE: state_r <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        req_r    <= '{opcode: in_ch.opcode, txn_id: in_ch.txn_id,
                      obj: {in_ch.resource_is_record, in_ch.resource_key}};
        add_r    <= 1'b0;
        group_r  <= nwsx_pkg::GM_NONE;
        ecnt_r   <= '0;
        found_r  <= 1'b0;
        free_ok_r <= 1'b0;
        found_idx_r <= '0;
        free_idx_r  <= '0;
        case (in_ch.opcode) inside
          nwsx_pkg::OP_LOCK_SH, nwsx_pkg::OP_LOCK_EX: begin
            if (in_ch.txn_phase == nwsx_pkg::PH_SHRINKING) begin
              status_r <= nwsx_pkg::ST_ABORT_SHRINK;
              phase_r  <= in_ch.txn_phase;
            end else if (in_ch.txn_phase == nwsx_pkg::PH_DEFAULT ||
                         in_ch.txn_phase == nwsx_pkg::PH_GROWING) begin
              status_r <= nwsx_pkg::ST_OK;
              phase_r  <= nwsx_pkg::PH_GROWING;
            end else begin
              status_r <= nwsx_pkg::ST_REFUSED;
              phase_r  <= in_ch.txn_phase;
            end
          end
          nwsx_pkg::OP_UNLOCK: begin
            if (in_ch.txn_phase == nwsx_pkg::PH_COMMITTED ||
                in_ch.txn_phase == nwsx_pkg::PH_ABORTED) begin
              status_r <= nwsx_pkg::ST_REFUSED;
              phase_r  <= in_ch.txn_phase;
            end else if (in_ch.txn_phase == nwsx_pkg::PH_GROWING) begin
              status_r <= nwsx_pkg::ST_OK;
              phase_r  <= nwsx_pkg::PH_SHRINKING;
            end else begin
              status_r <= nwsx_pkg::ST_OK;
              phase_r  <= in_ch.txn_phase;
            end
          end
          default: begin
            status_r <= nwsx_pkg::ST_REFUSED;
            phase_r  <= in_ch.txn_phase;
          end
        endcase
      end
      S_SCAN: begin
        if (ecnt_r != ECW'(T)) begin
          ecnt_r <= ecnt_r + ECW'(1);
        end
        if (ecnt_r != '0) begin
          // lowest entry that is unused or has no holders
          if (!free_ok_r && (!used_r[eprev] || mask_rdata == '0)) begin
            free_ok_r  <= 1'b1;
            free_idx_r <= eprev;
          end
          if (!found_r && used_r[eprev] && obj_rdata == req_r.obj) begin
            found_r     <= 1'b1;
            found_idx_r <= eprev;
          end
        end
      end
      S_PICK: begin
        ent_r      <= found_r ? found_idx_r : free_idx_r;
        mask_r     <= '0;
        hcnt_r     <= '0;
        hit_r      <= 1'b0;
        hit_idx_r  <= '0;
        hit_excl_r <= 1'b0;
        sfree_ok_r <= 1'b0;
        sfree_idx_r <= '0;
        nheld_r    <= '0;
        ex_r       <= 1'b0;
        sh_r       <= 1'b0;
        if (!found_r && !(is_lock && free_ok_r) && is_lock) begin
          status_r <= nwsx_pkg::ST_TABLE_FULL;
        end
      end
      S_HMASK: mask_r <= mask_rdata;
      S_WALK: begin
        if (hcnt_r != HCW'(H)) begin
          hcnt_r <= hcnt_r + HCW'(1);
        end
        if (hcnt_r != '0) begin
          if (mask_r[hprev]) begin
            nheld_r <= nheld_r + HCW'(1);
            if (!hit_r && slot_rdata.txn == req_r.txn_id) begin
              hit_r      <= 1'b1;
              hit_idx_r  <= hprev;
              hit_excl_r <= slot_rdata.excl;
            end else if (slot_rdata.excl) begin
              ex_r <= 1'b1;
            end else begin
              sh_r <= 1'b1;
            end
          end else if (!sfree_ok_r) begin
            sfree_ok_r  <= 1'b1;
            sfree_idx_r <= hprev;
          end
        end
      end
      S_WRITE: begin
        if (is_lock) begin
          if (hit_r) begin
            if (is_ex && !hit_excl_r && nheld_r != HCW'(1)) begin
              status_r <= nwsx_pkg::ST_ABORT_CONFLICT;
              group_r  <= cur_group;
            end else if (is_ex && !hit_excl_r) begin
              group_r <= nwsx_pkg::GM_EXCL;
            end else begin
              group_r <= cur_group;
            end
          end else if ((!is_ex && cur_group == nwsx_pkg::GM_EXCL) ||
                       (is_ex && cur_group != nwsx_pkg::GM_NONE)) begin
            status_r <= nwsx_pkg::ST_ABORT_CONFLICT;
            group_r  <= cur_group;
          end else if (!sfree_ok_r) begin
            status_r <= nwsx_pkg::ST_HOLDERS_FULL;
            group_r  <= cur_group;
          end else begin
            add_r   <= 1'b1;
            group_r <= is_ex ? nwsx_pkg::GM_EXCL : nwsx_pkg::GM_SHARED;
          end
        end else begin
          group_r <= rec_group;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_status_r <= status_r;
          out_phase_r  <= phase_r;
          out_add_r    <= add_r;
          out_group_r  <= group_r;
        end
      end
      default: ;
    endcase
  end

  assign in_ch.ready            = (state_r == S_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.new_txn_phase   = out_phase_r;
  assign out_ch.add_to_lock_set = out_add_r;
  assign out_ch.group_mode      = out_group_r;
endmodule

/* tb/sv/nwsx_lock_checker.sv */
// checker: predicts lock table results from request beats and compares result beats
module nwsx_lock_checker #(
  parameter int TABLE_ENTRIES     = 64,
  parameter int HOLDERS_PER_ENTRY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  nwsx_in_if          in_ch,
  nwsx_out_if         out_ch,
  output int          fail_count,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = TABLE_ENTRIES * HOLDERS_PER_ENTRY;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] phase;
    logic       add;
    logic [1:0] group;
  } lock_result_t;

  bit                         ent_used [TABLE_ENTRIES];
  logic [nwsx_pkg::OBJ_W-1:0] ent_obj  [TABLE_ENTRIES];
  logic [1:0]                 ent_grp  [TABLE_ENTRIES];
  bit                         hold_used[NSLOT];
  logic [15:0]                hold_txn [NSLOT];
  bit                         hold_ex  [NSLOT];

  lock_result_t expected_q[$];

  function automatic int find_holder(int e, logic [15:0] txn);
    for (int h = 0; h < HOLDERS_PER_ENTRY; h++)
      if (hold_used[e*HOLDERS_PER_ENTRY+h] && hold_txn[e*HOLDERS_PER_ENTRY+h] == txn)
        return e*HOLDERS_PER_ENTRY+h;
    return -1;
  endfunction

  function automatic lock_result_t grant_or_release(logic [1:0] op, logic [15:0] txn,
                                                    logic [2:0] ph,
                                                    logic [nwsx_pkg::OBJ_W-1:0] obj);
    lock_result_t r;
    int e, s, n;
    bit sh, ex;
    r = '{status: nwsx_pkg::ST_OK, phase: ph, add: 1'b0, group: nwsx_pkg::GM_NONE};
    e = -1;
    if (op == nwsx_pkg::OP_LOCK_SH || op == nwsx_pkg::OP_LOCK_EX) begin
      if (ph == nwsx_pkg::PH_SHRINKING) begin
        r.status = nwsx_pkg::ST_ABORT_SHRINK;
      end else if (ph != nwsx_pkg::PH_DEFAULT && ph != nwsx_pkg::PH_GROWING) begin
        r.status = nwsx_pkg::ST_REFUSED;
      end else begin
        r.phase = nwsx_pkg::PH_GROWING;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (e < 0 && ent_used[i] && ent_obj[i] == obj) e = i;
        if (e < 0) begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (e < 0 && (!ent_used[i] || ent_grp[i] == nwsx_pkg::GM_NONE)) e = i;
          if (e >= 0) begin
            ent_used[e] = 1;
            ent_obj[e] = obj;
            ent_grp[e] = nwsx_pkg::GM_NONE;
            for (int h = 0; h < HOLDERS_PER_ENTRY; h++) hold_used[e*HOLDERS_PER_ENTRY+h] = 0;
          end
        end
        if (e < 0) begin
          r.status = nwsx_pkg::ST_TABLE_FULL;
        end else begin
          s = find_holder(e, txn);
          if (s >= 0) begin
            if (op == nwsx_pkg::OP_LOCK_EX && !hold_ex[s]) begin
              n = 0;
              for (int h = 0; h < HOLDERS_PER_ENTRY; h++) n += hold_used[e*HOLDERS_PER_ENTRY+h];
              if (n != 1) begin
                r.status = nwsx_pkg::ST_ABORT_CONFLICT;
              end else begin
                hold_ex[s] = 1;
                ent_grp[e] = nwsx_pkg::GM_EXCL;
              end
            end
          end else if ((op == nwsx_pkg::OP_LOCK_SH && ent_grp[e] == nwsx_pkg::GM_EXCL) ||
                       (op == nwsx_pkg::OP_LOCK_EX && ent_grp[e] != nwsx_pkg::GM_NONE)) begin
            r.status = nwsx_pkg::ST_ABORT_CONFLICT;
          end else begin
            s = -1;
            for (int h = 0; h < HOLDERS_PER_ENTRY; h++)
              if (s < 0 && !hold_used[e*HOLDERS_PER_ENTRY+h]) s = e*HOLDERS_PER_ENTRY+h;
            if (s < 0) begin
              r.status = nwsx_pkg::ST_HOLDERS_FULL;
            end else begin
              hold_used[s] = 1;
              hold_txn[s] = txn;
              hold_ex[s] = (op == nwsx_pkg::OP_LOCK_EX);
              ent_grp[e] = (op == nwsx_pkg::OP_LOCK_EX) ? nwsx_pkg::GM_EXCL
                                                        : nwsx_pkg::GM_SHARED;
              r.add = 1;
            end
          end
          r.group = ent_grp[e];
        end
      end
    end else if (op == nwsx_pkg::OP_UNLOCK) begin
      if (ph == nwsx_pkg::PH_COMMITTED || ph == nwsx_pkg::PH_ABORTED) begin
        r.status = nwsx_pkg::ST_REFUSED;
      end else begin
        if (ph == nwsx_pkg::PH_GROWING) r.phase = nwsx_pkg::PH_SHRINKING;
        for (int i = 0; i < TABLE_ENTRIES; i++)
          if (e < 0 && ent_used[i] && ent_obj[i] == obj) e = i;
        if (e >= 0) begin
          s = find_holder(e, txn);
          if (s >= 0) hold_used[s] = 0;
          sh = 0;
          ex = 0;
          for (int h = 0; h < HOLDERS_PER_ENTRY; h++)
            if (hold_used[e*HOLDERS_PER_ENTRY+h]) begin
              if (hold_ex[e*HOLDERS_PER_ENTRY+h]) ex = 1;
              else sh = 1;
            end
          ent_grp[e] = ex ? nwsx_pkg::GM_EXCL :
                       (sh ? nwsx_pkg::GM_SHARED : nwsx_pkg::GM_NONE);
          r.group = ent_grp[e];
        end
      end
    end else begin
      r.status = nwsx_pkg::ST_REFUSED;
    end
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    lock_result_t got, want;
    if (!rst_n) begin
      fail_count <= 0;
      expected_q.delete();
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        ent_used[i] = 0;
        ent_grp[i] = nwsx_pkg::GM_NONE;
      end
      for (int i = 0; i < NSLOT; i++) hold_used[i] = 0;
    end else begin
      if (in_ch.valid && in_ch.ready)
        expected_q.push_back(grant_or_release(in_ch.opcode, in_ch.txn_id, in_ch.txn_phase,
                                              {in_ch.resource_is_record, in_ch.resource_key}));
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.status, out_ch.new_txn_phase, out_ch.add_to_lock_set, out_ch.group_mode};
        if (expected_q.size() == 0) begin
          if (fail_count < 10) $display("unexpected result beat %p", got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

/* tb/sv/no_wait_shared_exclusive_lock_table_core_tb.sv */
// testbench top: drives lock requests, stalls results and reports the verdict
module no_wait_shared_exclusive_lock_table_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int N_RANDOM = 430;
  localparam int LIMIT    = 2000000;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending, cycles;

  nwsx_in_if  in_ch ();
  nwsx_out_if out_ch ();

  no_wait_shared_exclusive_lock_table_core DUT (.clk, .rst_n, .in_ch, .out_ch);
  nwsx_lock_checker checker_i (.clk, .rst_n, .in_ch, .out_ch, .fail_count, .pending);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.opcode = nwsx_pkg::OP_LOCK_SH;
    in_ch.txn_id = 0;
    in_ch.txn_phase = nwsx_pkg::PH_DEFAULT;
    in_ch.resource_key = 0;
    in_ch.resource_is_record = 0;
    out_ch.ready = 0;
  end

  // result stall pattern: long open stretches, then spells of random stalls
  always @(posedge clk) begin
    int r;
    r = (cycles / 500) % 3;
    if (r == 0) out_ch.ready <= 1'b1;
    else if (r == 1) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= ($urandom_range(0, 1) != 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("no_wait_shared_exclusive_lock_table_core_tb NOT OK");
      $finish;
    end
  end
  initial cycles = 0;

  int burst_left = 0;

  task automatic send_req(logic [1:0] op, logic [15:0] txn, logic [2:0] ph,
                          logic [31:0] key, logic rec);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 4);
      if (gap != 0) begin
        in_ch.valid <= 0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    in_ch.valid <= 1;
    in_ch.opcode <= op;
    in_ch.txn_id <= txn;
    in_ch.txn_phase <= ph;
    in_ch.resource_key <= key;
    in_ch.resource_is_record <= rec;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  logic [31:0] key_pool[8];

  initial begin
    int op, sel;
    logic [2:0] ph;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: phases, modes, upgrade, conflicts, unknown opcode, extremes
    send_req(nwsx_pkg::OP_LOCK_SH, 16'h0000, nwsx_pkg::PH_DEFAULT, 32'h0, 0);
    send_req(nwsx_pkg::OP_LOCK_SH, 16'hFFFF, nwsx_pkg::PH_GROWING, 32'h0, 0);
    send_req(nwsx_pkg::OP_LOCK_EX, 16'h0000, nwsx_pkg::PH_GROWING, 32'h0, 0);
    send_req(nwsx_pkg::OP_UNLOCK, 16'hFFFF, nwsx_pkg::PH_GROWING, 32'h0, 0);
    send_req(nwsx_pkg::OP_LOCK_EX, 16'h0000, nwsx_pkg::PH_GROWING, 32'h0, 0);
    send_req(nwsx_pkg::OP_LOCK_EX, 16'h0000, nwsx_pkg::PH_GROWING, 32'h0, 0);
    send_req(nwsx_pkg::OP_LOCK_SH, 16'h1234, nwsx_pkg::PH_DEFAULT, 32'h0, 0);
    send_req(nwsx_pkg::OP_LOCK_SH, 16'h0000, nwsx_pkg::PH_SHRINKING, 32'hFFFFFFFF, 1);
    send_req(nwsx_pkg::OP_LOCK_EX, 16'h0001, nwsx_pkg::PH_COMMITTED, 32'hFFFFFFFF, 1);
    send_req(nwsx_pkg::OP_LOCK_SH, 16'h0001, nwsx_pkg::PH_ABORTED, 32'hFFFFFFFF, 1);
    send_req(nwsx_pkg::OP_LOCK_SH, 16'h0001, 3'd7, 32'hFFFFFFFF, 1);
    send_req(2'd3, 16'h0001, nwsx_pkg::PH_GROWING, 32'hFFFFFFFF, 1);
    send_req(nwsx_pkg::OP_UNLOCK, 16'h0001, nwsx_pkg::PH_COMMITTED, 32'h0, 0);
    send_req(nwsx_pkg::OP_UNLOCK, 16'h0001, nwsx_pkg::PH_ABORTED, 32'h0, 0);
    send_req(nwsx_pkg::OP_UNLOCK, 16'h0001, 3'd5, 32'h0, 0);
    send_req(nwsx_pkg::OP_UNLOCK, 16'h0001, nwsx_pkg::PH_DEFAULT, 32'hABCDEF01, 1);
    send_req(nwsx_pkg::OP_UNLOCK, 16'h0000, nwsx_pkg::PH_SHRINKING, 32'h0, 0);
    // fill one holder list past its end
    for (int i = 0; i < 18; i++)
      send_req(nwsx_pkg::OP_LOCK_SH, 16'(100 + i), nwsx_pkg::PH_GROWING, 32'h55, 1);
    // fill the table past its end with exclusive locks
    for (int i = 0; i < 66; i++)
      send_req(nwsx_pkg::OP_LOCK_EX, 16'h0777, nwsx_pkg::PH_GROWING, 32'(1000 + i), 0);
    for (int i = 0; i < 66; i++)
      send_req(nwsx_pkg::OP_UNLOCK, 16'h0777, nwsx_pkg::PH_GROWING, 32'(1000 + i), 0);
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    // random: mostly well-formed traffic on a few hot objects and txns
    for (int n = 0; n < N_RANDOM; n++) begin
      sel = $urandom_range(0, 9);
      op = $urandom_range(0, 9);
      op = (op < 4) ? nwsx_pkg::OP_LOCK_SH : (op < 7) ? nwsx_pkg::OP_LOCK_EX :
           (op < 9) ? nwsx_pkg::OP_UNLOCK : 3;
      ph = (sel < 8) ? ($urandom_range(0, 1) ? nwsx_pkg::PH_GROWING : nwsx_pkg::PH_DEFAULT)
                     : 3'($urandom);
      if (sel < 9)
        send_req(2'(op), 16'($urandom_range(0, 5)), ph, key_pool[$urandom_range(0, 7)],
                 1'($urandom));
      else
        send_req(2'($urandom), 16'($urandom), ph, $urandom, 1'($urandom));
    end
    in_ch.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) $display("no_wait_shared_exclusive_lock_table_core_tb OK");
    else $display("no_wait_shared_exclusive_lock_table_core_tb NOT OK");
    $finish;
  end
endmodule
